@@ design/nrfc_pkg.sv @@
// Shared types and constants for the response frame checker.
package nrfc_pkg;

  localparam int ByteW = 8;
  localparam int PhaseW = 4;
  localparam int StatusW = 2;

  localparam logic [ByteW-1:0] TfiIn = 8'hD5;
  localparam logic [ByteW-1:0] StartHi = 8'hFF;
  localparam logic [ByteW-1:0] ZeroByte = 8'h00;

  localparam logic [StatusW-1:0] StatusOk = 2'd0;
  localparam logic [StatusW-1:0] StatusBadHeader = 2'd1;
  localparam logic [StatusW-1:0] StatusBadSum = 2'd2;
  localparam logic [StatusW-1:0] StatusBadPost = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             frame_start;
    logic [ByteW-1:0] expected_command;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0]   payload_byte;
    logic               is_payload;
    logic               frame_done;
    logic [StatusW-1:0] frame_status;
  } result_t;

endpackage

@@ design/nrfc_in_reg.sv @@
// Input register stage that holds one received byte and its side fields.
module nrfc_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  nrfc_pkg::item_t in_item,
  output logic          item_valid,
  output nrfc_pkg::item_t item,
  input  logic          item_take
);

  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

@@ design/nrfc_parser.sv @@
// Frame phases, header checks, data checksum; a byte per cycle unless stalled.
module nrfc_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  nrfc_pkg::item_t   item,
  input  logic              can_load,
  output logic              item_take,
  output logic              res_valid,
  output nrfc_pkg::result_t res
);

  localparam logic [nrfc_pkg::PhaseW-1:0] PhIdle    = 4'd0;
  localparam logic [nrfc_pkg::PhaseW-1:0] PhSc0     = 4'd1;
  localparam logic [nrfc_pkg::PhaseW-1:0] PhSc1     = 4'd2;
  localparam logic [nrfc_pkg::PhaseW-1:0] PhLen     = 4'd3;
  localparam logic [nrfc_pkg::PhaseW-1:0] PhLcs     = 4'd4;
  localparam logic [nrfc_pkg::PhaseW-1:0] PhTfi     = 4'd5;
  localparam logic [nrfc_pkg::PhaseW-1:0] PhCode    = 4'd6;
  localparam logic [nrfc_pkg::PhaseW-1:0] PhPayload = 4'd7;
  localparam logic [nrfc_pkg::PhaseW-1:0] PhDcs     = 4'd8;
  localparam logic [nrfc_pkg::PhaseW-1:0] PhPost    = 4'd9;

  logic [nrfc_pkg::PhaseW-1:0] frame_phase, frame_phase_next;
  logic [nrfc_pkg::ByteW-1:0]  payload_left, payload_left_next;
  logic [nrfc_pkg::ByteW-1:0]  length_seen, length_seen_next;
  logic [nrfc_pkg::ByteW-1:0]  running_sum, running_sum_next;
  logic                        header_good, header_good_next;
  logic [nrfc_pkg::ByteW-1:0]  wanted_command, wanted_command_next;

  logic [nrfc_pkg::ByteW-1:0] b;
  logic [nrfc_pkg::ByteW-1:0] sum_plus_b;
  logic                       produces;

  assign b = item.rx_byte;
  assign sum_plus_b = running_sum + b;
  assign item_take = can_load;
  assign res_valid = item_valid && produces;

  always_comb begin
    frame_phase_next    = frame_phase;
    payload_left_next   = payload_left;
    length_seen_next    = length_seen;
    running_sum_next    = running_sum;
    header_good_next    = header_good;
    wanted_command_next = wanted_command;
    produces            = 1'b0;
    res                 = '0;

    if (item.frame_start) begin
      wanted_command_next = item.expected_command;
      running_sum_next    = '0;
      header_good_next    = 1'b1;
      length_seen_next    = '0;
      payload_left_next   = '0;
      frame_phase_next    = PhSc0;
    end else begin
      case (frame_phase)
        PhSc0: begin
          if (b != nrfc_pkg::ZeroByte) header_good_next = 1'b0;
          frame_phase_next = PhSc1;
        end
        PhSc1: begin
          if (b != nrfc_pkg::StartHi) header_good_next = 1'b0;
          frame_phase_next = PhLen;
        end
        PhLen: begin
          length_seen_next = b;
          if (b < 8'd2) begin
            header_good_next  = 1'b0;
            payload_left_next = '0;
          end else begin
            payload_left_next = b - 8'd2;
          end
          frame_phase_next = PhLcs;
        end
        PhLcs: begin
          if (8'(length_seen + b) != 8'd0) header_good_next = 1'b0;
          frame_phase_next = PhTfi;
        end
        PhTfi: begin
          if (b != nrfc_pkg::TfiIn) header_good_next = 1'b0;
          running_sum_next = sum_plus_b;
          frame_phase_next = PhCode;
        end
        PhCode: begin
          // A command of 0xFF expects 0x100, which no byte can match.
          if ({1'b0, b} != ({1'b0, wanted_command} + 9'd1)) header_good_next = 1'b0;
          running_sum_next = sum_plus_b;
          frame_phase_next = (payload_left != '0) ? PhPayload : PhDcs;
        end
        PhPayload: begin
          running_sum_next  = sum_plus_b;
          payload_left_next = payload_left - 8'd1;
          if (payload_left == 8'd1) frame_phase_next = PhDcs;
          produces         = 1'b1;
          res.payload_byte = b;
          res.is_payload   = 1'b1;
        end
        PhDcs: begin
          running_sum_next = sum_plus_b;
          frame_phase_next = PhPost;
        end
        PhPost: begin
          produces       = 1'b1;
          res.frame_done = 1'b1;
          if (!header_good) res.frame_status = nrfc_pkg::StatusBadHeader;
          else if (running_sum != '0) res.frame_status = nrfc_pkg::StatusBadSum;
          else if (b != nrfc_pkg::ZeroByte) res.frame_status = nrfc_pkg::StatusBadPost;
          else res.frame_status = nrfc_pkg::StatusOk;
          frame_phase_next = PhIdle;
        end
        default: begin
          frame_phase_next = PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase    <= PhIdle;
      payload_left   <= '0;
      length_seen    <= '0;
      running_sum    <= '0;
      header_good    <= 1'b1;
      wanted_command <= '0;
    end else if (item_valid && can_load) begin
      frame_phase    <= frame_phase_next;
      payload_left   <= payload_left_next;
      length_seen    <= length_seen_next;
      running_sum    <= running_sum_next;
      header_good    <= header_good_next;
      wanted_command <= wanted_command_next;
    end
  end

endmodule

@@ design/nrfc_out_reg.sv @@
// Output register that holds one result until the receiver takes it.
module nrfc_out_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      res_valid,
  input  nrfc_pkg::result_t         res,
  output logic                      can_load,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [nrfc_pkg::ByteW-1:0]   payload_byte,
  output logic                      is_payload,
  output logic                      frame_done,
  output logic [nrfc_pkg::StatusW-1:0] frame_status
);

  nrfc_pkg::result_t held;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && res_valid) begin
      held <= res;
    end
  end

  assign payload_byte = held.payload_byte;
  assign is_payload   = held.is_payload;
  assign frame_done   = held.frame_done;
  assign frame_status = held.frame_status;

endmodule

@@ design/nfc_response_frame_checker_core.sv @@
// Top level of the response frame checker: input register, parser and output register.
//
// Usage: received frame bytes enter on the input channel (in_valid / in_ready) in wire
// order, one transfer per byte, with frame_start high on the preamble byte of each frame
// and expected_command holding the command code that was sent. Results leave on the
// output channel (out_valid / out_ready): one transfer per payload byte with is_payload
// set, and one status transfer with frame_done set on the postamble byte. Bytes of the
// header, the checksum and bytes seen while idle give no result.
// A byte accepted into the input register goes through the combinational parser into the
// output register, from which its result transfer is made.
// Throughput is one byte per cycle while the output is not stalled; the single parser
// stage sets this, as its frame state is updated once per byte.
// Reset clears the input and output registers and returns the parser to idle, waiting
// for a frame start; no result is pending after reset.
// When the receiver stalls, the output register holds its result, the parser stops and
// the input register holds one more byte; in_ready falls only while both registers are
// full and the output is not being taken, so no byte or result is lost or repeated.
// A frame start at any point abandons the current frame without a status result.
module nfc_response_frame_checker_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  input  logic [7:0] expected_command,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] payload_byte,
  output logic       is_payload,
  output logic       frame_done,
  output logic [1:0] frame_status
);

  nrfc_pkg::item_t   in_item;
  nrfc_pkg::item_t   item;
  nrfc_pkg::result_t res;
  logic              item_valid;
  logic              item_take;
  logic              res_valid;
  logic              can_load;

  // Pack the input fields into one item for the input register.
  assign in_item.rx_byte          = rx_byte;
  assign in_item.frame_start      = frame_start;
  assign in_item.expected_command = expected_command;

  nrfc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // The parser consumes the held byte whenever the output register can take a result,
  // whether or not this byte produces one.
  nrfc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .can_load   (can_load),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res)
  );

  nrfc_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res          (res),
    .can_load     (can_load),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .is_payload   (is_payload),
    .frame_done   (frame_done),
    .frame_status (frame_status)
  );

endmodule

@@ design/nrfc_checker.sv @@
// Port-level assertions for the response frame checker and their bind.
module nrfc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] payload_byte,
  input logic       is_payload,
  input logic       frame_done,
  input logic [1:0] frame_status
);

  // No result may be pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result stays put until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(is_payload)
      && $stable(frame_done) && $stable(frame_status))
    else $error("stalled result changed");

  // Every result is exactly one kind: a payload byte or a frame status.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_payload != frame_done))
    else $error("result is neither or both of payload and status");

  // Payload results carry a zero status and status results a zero byte.
  a_clean_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_payload ? (frame_status == nrfc_pkg::StatusOk)
                              : (payload_byte == 8'h00)))
    else $error("unused result field not zero");

endmodule

bind nfc_response_frame_checker_core nrfc_checker u_nrfc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .payload_byte (payload_byte),
  .is_payload   (is_payload),
  .frame_done   (frame_done),
  .frame_status (frame_status)
);
